### design/bvasp_pkg.sv
`default_nettype none
package bvasp_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int WIN_AW     = $clog2(MAX_WINDOW);
	localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);
	localparam int POS_BITS   = 16;
	localparam int VEL_BITS   = 15;
	localparam int SUM_BITS   = 20;
	localparam int SQ1_BITS   = 29;
	localparam int SQ_BITS    = 30;
	localparam int MAG_BITS   = 19;
	localparam int RAD_BITS   = 2 * MAG_BITS;
	localparam int SRT_REM    = MAG_BITS + 2;
	localparam int SRT_IT_W   = $clog2(MAG_BITS + 1);
	localparam int DVD_BITS   = VEL_BITS + MAG_BITS;
	localparam int DVS_BITS   = 21;
	localparam int DIV_IT_W   = $clog2(DVD_BITS + 1);
	localparam int THR_BITS   = 14;
	localparam int DEC_BITS   = 16;
	localparam int LEN_BITS   = 5;
	localparam int CFG_BITS   = 16;
	localparam int STP_BITS   = DVD_BITS + 2;

	typedef enum logic [1:0] {
		CFG_WINDOW_LEN = 2'd0,
		CFG_DECEL      = 2'd1,
		CFG_STOP_SPEED = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              wr_en;
		logic [WIN_AW-1:0] wr_addr;
		logic              rd_en;
		logic [WIN_AW-1:0] rd_addr;
	} win_ctl_t;

	typedef struct packed {
		logic                start;
		logic [DVD_BITS-1:0] dvd;
		logic [DVS_BITS-1:0] dvs;
	} div_req_t;

	typedef struct packed {
		logic                start;
		logic [RAD_BITS-1:0] rad;
	} sqrt_req_t;

endpackage
`default_nettype wire

### design/bvasp_win.sv
`default_nettype none
module bvasp_win (
	input  wire                                    clk,
	input  wire bvasp_pkg::win_ctl_t               ctl,
	input  wire [2*bvasp_pkg::VEL_BITS-1:0]        wr_data,
	output logic [2*bvasp_pkg::VEL_BITS-1:0]       rd_data
);

	// sample ring: {vx, vy} per entry, one write and one registered read per cycle
	logic [2*bvasp_pkg::VEL_BITS-1:0] mem [bvasp_pkg::MAX_WINDOW];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[ctl.rd_addr];
		end
	end

endmodule
`default_nettype wire

### design/bvasp_div.sv
`default_nettype none
module bvasp_div (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire bvasp_pkg::div_req_t             req,
	output logic                                 done,
	output logic [bvasp_pkg::DVD_BITS-1:0]       quo
);

	localparam int DN = bvasp_pkg::DVD_BITS;
	localparam int DS = bvasp_pkg::DVS_BITS;

	logic [DN-1:0] dvd_q;
	logic [DS-1:0] dvs_q;
	logic [DS-1:0] rem_q;
	logic [bvasp_pkg::DIV_IT_W-1:0] it_q;
	logic busy_q;
	logic done_q;
	logic [DS:0] rem_sh;
	logic [DS:0] rem_nx;
	logic ge;

	// restoring division, one quotient bit a cycle
	always_comb begin
		rem_sh = {rem_q, dvd_q[DN-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				it_q   <= bvasp_pkg::DIV_IT_W'(DN);
			end else if (busy_q) begin
				it_q <= it_q - 1'b1;
				if (it_q == bvasp_pkg::DIV_IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dvd;
			dvs_q <= req.dvs;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DN-2:0], ge};
			rem_q <= rem_nx[DS-1:0];
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;

endmodule
`default_nettype wire

### design/bvasp_sqrt.sv
`default_nettype none
module bvasp_sqrt (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire bvasp_pkg::sqrt_req_t            req,
	output logic                                 done,
	output logic [bvasp_pkg::MAG_BITS-1:0]       root
);

	localparam int RB = bvasp_pkg::RAD_BITS;
	localparam int MB = bvasp_pkg::MAG_BITS;
	localparam int RM = bvasp_pkg::SRT_REM;

	logic [RB-1:0] rad_q;
	logic [RM-1:0] rem_q;
	logic [MB-1:0] root_q;
	logic [bvasp_pkg::SRT_IT_W-1:0] it_q;
	logic busy_q;
	logic done_q;
	logic [RM+1:0] rem_sh;
	logic [RM+1:0] trial;
	logic [RM+1:0] rem_nx;
	logic ge;

	// digit-by-digit square root, two radicand bits a cycle
	always_comb begin
		rem_sh = {rem_q, rad_q[RB-1 -: 2]};
		trial  = (RM + 2)'({root_q, 2'b01});
		ge     = rem_sh >= trial;
		rem_nx = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				it_q   <= bvasp_pkg::SRT_IT_W'(MB);
			end else if (busy_q) begin
				it_q <= it_q - 1'b1;
				if (it_q == bvasp_pkg::SRT_IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RB-3:0], 2'b00};
			rem_q  <= rem_nx[RM-1:0];
			root_q <= {root_q[MB-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

### design/ball_velocity_average_stop_predict_unit.sv
// Sequence: sum the n held samples, then four divides on the shared divider
// (two averages, two displacements), a square root and five further steps
// (SQX, SQY, MULX, MULY, OUT); the average divides are skipped while no sample is held.
// A new transaction is accepted only after the last one has left S_OUT; the divider dominates the run time.
// Reset (arst_n, asynchronous): config to 8 / 500 / 50, counts and position
// to zero; the sums and the sample memory are not cleared.
`default_nettype none
module ball_velocity_average_stop_predict_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_wr_en,
	input  wire [1:0]                             cfg_index,
	input  wire [bvasp_pkg::CFG_BITS-1:0]         cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire                                   func,
	input  wire signed [bvasp_pkg::POS_BITS-1:0]  pos_x,
	input  wire signed [bvasp_pkg::POS_BITS-1:0]  pos_y,
	input  wire signed [bvasp_pkg::VEL_BITS-1:0]  vel_x,
	input  wire signed [bvasp_pkg::VEL_BITS-1:0]  vel_y,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [bvasp_pkg::VEL_BITS-1:0] avg_vel_x,
	output logic signed [bvasp_pkg::VEL_BITS-1:0] avg_vel_y,
	output logic signed [bvasp_pkg::POS_BITS-1:0] stop_x,
	output logic signed [bvasp_pkg::POS_BITS-1:0] stop_y,
	output logic                                  stopped
);

	localparam int VB = bvasp_pkg::VEL_BITS;
	localparam int PB = bvasp_pkg::POS_BITS;
	localparam int SB = bvasp_pkg::SUM_BITS;
	localparam int CB = bvasp_pkg::CNT_BITS;
	localparam int DN = bvasp_pkg::DVD_BITS;
	localparam int DS = bvasp_pkg::DVS_BITS;
	localparam int MB = bvasp_pkg::MAG_BITS;
	localparam int TB = bvasp_pkg::STP_BITS;

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_SUM  = 12'b0000_0000_0010,
		S_DIVX = 12'b0000_0000_0100,
		S_DIVY = 12'b0000_0000_1000,
		S_SQX  = 12'b0000_0001_0000,
		S_SQY  = 12'b0000_0010_0000,
		S_SQRT = 12'b0000_0100_0000,
		S_MULX = 12'b0000_1000_0000,
		S_DDX  = 12'b0001_0000_0000,
		S_MULY = 12'b0010_0000_0000,
		S_DDY  = 12'b0100_0000_0000,
		S_OUT  = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [bvasp_pkg::LEN_BITS-1:0] win_len_q;
	logic [bvasp_pkg::DEC_BITS-1:0] decel_q;
	logic [bvasp_pkg::THR_BITS-1:0] thr_q;

	// window bookkeeping and position
	logic [CB-1:0]                  cnt_q;
	logic [bvasp_pkg::WIN_AW-1:0]   wslot_q;
	logic signed [PB-1:0]           px_q;
	logic signed [PB-1:0]           py_q;

	// summing sweep
	logic [CB-1:0]                  k_q;
	logic                           pend_s1;
	logic signed [SB-1:0]           sumx_q;
	logic signed [SB-1:0]           sumy_q;

	// arithmetic results
	logic signed [VB-1:0]           ax_q;
	logic signed [VB-1:0]           ay_q;
	logic [bvasp_pkg::SQ1_BITS-1:0] sqx_q;
	logic [bvasp_pkg::SQ_BITS-1:0]  sq_q;
	logic [2*bvasp_pkg::THR_BITS-1:0] thr2_q;
	logic [MB-1:0]                  mag_q;
	logic [DN-1:0]                  prod_q;
	logic                           stopped_q;
	logic signed [PB-1:0]           sx_q;
	logic signed [PB-1:0]           sy_q;
	logic                           launch_q;

	// output register
	logic                           out_valid_q;
	logic signed [VB-1:0]           oax_q;
	logic signed [VB-1:0]           oay_q;
	logic signed [PB-1:0]           osx_q;
	logic signed [PB-1:0]           osy_q;
	logic                           ostop_q;

	logic                           accept;
	logic                           issue;
	logic                           out_load;
	logic [CB-1:0]                  len_eff;
	logic [DS-1:0]                  den;
	bvasp_pkg::win_ctl_t            win_ctl;
	logic [2*VB-1:0]                rd_data;
	bvasp_pkg::div_req_t            div_req;
	logic                           div_done;
	logic [DN-1:0]                  quo;
	bvasp_pkg::sqrt_req_t           sqrt_req;
	logic                           sqrt_done;
	logic [MB-1:0]                  root;
	logic [SB-1:0]                  absx;
	logic [SB-1:0]                  absy;
	logic [VB-1:0]                  axmag;
	logic [VB-1:0]                  aymag;
	logic signed [2*VB-1:0]         sq_axis;
	logic signed [TB-1:0]           stop_sum;
	logic signed [PB-1:0]           stop_sat;
	logic signed [VB-1:0]           avg_val;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// clamp the window length into 1..MAX_WINDOW, deceleration zero acts as one
	always_comb begin
		if (win_len_q == '0) begin
			len_eff = CB'(1);
		end else if (32'(win_len_q) > bvasp_pkg::MAX_WINDOW) begin
			len_eff = CB'(bvasp_pkg::MAX_WINDOW);
		end else begin
			len_eff = CB'(win_len_q);
		end
		den = DS'({(decel_q == '0) ? bvasp_pkg::DEC_BITS'(1) : decel_q, 5'b00000});
	end

	// issue one memory read a cycle, newest sample first; the sample write of
	// a sample transaction lands at the accept edge, before the first read
	assign issue = (state_q == S_SUM) && (k_q < cnt_q);

	always_comb begin
		win_ctl.wr_en   = accept && !func;
		win_ctl.wr_addr = wslot_q;
		win_ctl.rd_en   = issue;
		win_ctl.rd_addr = wslot_q - bvasp_pkg::WIN_AW'(1) - k_q[bvasp_pkg::WIN_AW-1:0];
	end

	bvasp_win u_win (
		.clk     (clk),
		.ctl     (win_ctl),
		.wr_data ({vel_x, vel_y}),
		.rd_data (rd_data)
	);

	// magnitudes for the sign-magnitude divides
	always_comb begin
		absx  = sumx_q[SB-1] ? SB'(-sumx_q) : SB'(sumx_q);
		absy  = sumy_q[SB-1] ? SB'(-sumy_q) : SB'(sumy_q);
		axmag = ax_q[VB-1] ? VB'(-ax_q) : VB'(ax_q);
		aymag = ay_q[VB-1] ? VB'(-ay_q) : VB'(ay_q);
	end

	// shared divider: averages by the held count, displacement by 32 * decel
	always_comb begin
		div_req.start = launch_q && (state_q == S_DIVX || state_q == S_DIVY ||
			state_q == S_DDX || state_q == S_DDY);
		unique case (state_q)
			S_DIVX: begin
				div_req.dvd = DN'(absx);
				div_req.dvs = DS'(cnt_q);
			end
			S_DIVY: begin
				div_req.dvd = DN'(absy);
				div_req.dvs = DS'(cnt_q);
			end
			default: begin
				div_req.dvd = prod_q;
				div_req.dvs = den;
			end
		endcase
	end

	bvasp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (quo)
	);

	// |v| with four fraction bits
	always_comb begin
		sqrt_req.start = launch_q && (state_q == S_SQRT);
		sqrt_req.rad   = bvasp_pkg::RAD_BITS'({sq_q, 8'h00});
	end

	bvasp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.done   (sqrt_done),
		.root   (root)
	);

	// square of one axis, x in SQX and y in SQY
	assign sq_axis = (state_q == S_SQX) ? ax_q * ax_q : ay_q * ay_q;

	// signed quotient of the current average divide, truncated toward zero
	assign avg_val = ((state_q == S_DIVX) ? sumx_q[SB-1] : sumy_q[SB-1]) ?
		VB'(-quo[VB-1:0]) : VB'(quo[VB-1:0]);

	// stop point: position plus signed displacement, saturated
	always_comb begin
		logic neg;
		logic signed [PB-1:0] pos;
		neg = (state_q == S_DDX) ? ax_q[VB-1] : ay_q[VB-1];
		pos = (state_q == S_DDX) ? px_q : py_q;
		stop_sum = TB'(pos) + (neg ? -TB'(quo) : TB'(quo));
		if (stop_sum > TB'(signed'({1'b0, {(PB-1){1'b1}}}))) begin
			stop_sat = {1'b0, {(PB-1){1'b1}}};
		end else if (stop_sum < TB'(signed'({1'b1, {(PB-1){1'b0}}}))) begin
			stop_sat = {1'b1, {(PB-1){1'b0}}};
		end else begin
			stop_sat = stop_sum[PB-1:0];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= bvasp_pkg::LEN_BITS'(8);
			decel_q   <= bvasp_pkg::DEC_BITS'(500);
			thr_q     <= bvasp_pkg::THR_BITS'(50);
		end else if (cfg_wr_en) begin
			unique case (bvasp_pkg::cfg_idx_t'(cfg_index))
				bvasp_pkg::CFG_WINDOW_LEN: win_len_q <= cfg_data[bvasp_pkg::LEN_BITS-1:0];
				bvasp_pkg::CFG_DECEL:      decel_q   <= cfg_data[bvasp_pkg::DEC_BITS-1:0];
				bvasp_pkg::CFG_STOP_SPEED: thr_q     <= cfg_data[bvasp_pkg::THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			pend_s1     <= 1'b0;
			cnt_q       <= '0;
			wslot_q     <= '0;
			px_q        <= '0;
			py_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// pulse a start for the unit the next state hands work to
			launch_q <= (state_q == S_SUM && !issue && !pend_s1 && cnt_q != '0) ||
				(state_q == S_DIVX && div_done) || (state_q == S_SQY) ||
				(state_q == S_MULX) || (state_q == S_MULY);
			pend_s1  <= issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func) begin
							px_q <= pos_x;
							py_q <= pos_y;
						end else begin
							wslot_q <= wslot_q + 1'b1;
							if (cnt_q < len_eff) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					// wait for the last read to land before dividing or, with no sample held, squaring
					if (!issue && !pend_s1) begin
						if (cnt_q == '0) begin
							state_q <= S_SQX;
						end else begin
							state_q <= S_DIVX;
						end
					end
				end
				S_DIVX: begin
					if (div_done) begin
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_done) begin
						state_q <= S_SQX;
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_SQRT;
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_MULX;
					end
				end
				S_MULX: state_q <= S_DDX;
				S_DDX: begin
					if (div_done) begin
						state_q <= S_MULY;
					end
				end
				S_MULY: state_q <= S_DDY;
				S_DDY: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register frees up
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			k_q    <= '0;
			sumx_q <= '0;
			sumy_q <= '0;
			ax_q   <= '0;
			ay_q   <= '0;
		end
		if (issue) begin
			k_q <= k_q + 1'b1;
		end
		if (pend_s1) begin
			sumx_q <= sumx_q + SB'(signed'(rd_data[2*VB-1:VB]));
			sumy_q <= sumy_q + SB'(signed'(rd_data[VB-1:0]));
		end
		if (state_q == S_DIVX && div_done) begin
			ax_q <= avg_val;
		end
		if (state_q == S_DIVY && div_done) begin
			ay_q <= avg_val;
		end
		if (state_q == S_SQX) begin
			sqx_q <= bvasp_pkg::SQ1_BITS'(sq_axis);
		end
		if (state_q == S_SQY) begin
			sq_q <= bvasp_pkg::SQ_BITS'(sqx_q) + bvasp_pkg::SQ_BITS'(sq_axis);
		end
		if (state_q == S_SQRT) begin
			thr2_q <= thr_q * thr_q;
		end
		if (state_q == S_SQRT && sqrt_done) begin
			mag_q <= root;
		end
		if (state_q == S_MULX) begin
			prod_q    <= DN'(axmag) * DN'(mag_q);
			stopped_q <= sq_q < bvasp_pkg::SQ_BITS'(thr2_q);
		end
		if (state_q == S_MULY) begin
			prod_q <= DN'(aymag) * DN'(mag_q);
		end
		if (state_q == S_DDX && div_done) begin
			sx_q <= stop_sat;
		end
		if (state_q == S_DDY && div_done) begin
			sy_q <= stop_sat;
		end
		if (out_load) begin
			oax_q   <= ax_q;
			oay_q   <= ay_q;
			osx_q   <= sx_q;
			osy_q   <= sy_q;
			ostop_q <= stopped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign avg_vel_x = oax_q;
	assign avg_vel_y = oay_q;
	assign stop_x    = osx_q;
	assign stop_y    = osy_q;
	assign stopped   = ostop_q;

endmodule
`default_nettype wire

### design/bvasp_chk.sv
`default_nettype none
module bvasp_chk (
	input wire                                   clk,
	input wire                                   arst_n,
	input wire                                   in_valid,
	input wire                                   in_stall,
	input wire                                   out_valid,
	input wire                                   out_stall,
	input wire signed [bvasp_pkg::VEL_BITS-1:0]  avg_vel_x,
	input wire signed [bvasp_pkg::VEL_BITS-1:0]  avg_vel_y,
	input wire signed [bvasp_pkg::POS_BITS-1:0]  stop_x,
	input wire signed [bvasp_pkg::POS_BITS-1:0]  stop_y,
	input wire                                   stopped
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(avg_vel_x) && $stable(avg_vel_y) &&
		$stable(stop_x) && $stable(stop_y) && $stable(stopped))
		else $error("stalled result changed");

	// one transaction at a time
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// the block frees its input only after posting a result
	a_free_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("input freed without a result");

endmodule

bind ball_velocity_average_stop_predict_unit bvasp_chk u_bvasp_chk (.*);
`default_nettype wire
